// ===== src/cossim_pkg.sv =====
package cossim_pkg;

    // Field widths
    localparam int ID_W     = 24;
    localparam int WEIGHT_W = 16;
    localparam int SIM_W    = 16;

    // Default vector length limit
    localparam int DEF_MAX_TERMS = 64;

    // Sequencer lengths of the score calculation
    localparam int MULT_STEPS = 8;    // two products, four partial products each
    localparam int DIV_STEPS  = 31;   // one quotient bit per step
    localparam int SQRT_STEPS = 16;   // one root bit per step
    localparam int STEP_W     = 5;
    localparam int MUL_IDX_W  = 3;

    // Divider and square root widths
    localparam int QUOT_W = 31;
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;
    localparam int REM_W  = 19;

    localparam logic [SIM_W-1:0] SIM_POS_MAX = 16'h7FFF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 acc_en;
        logic                 mul_en;
        logic [MUL_IDX_W-1:0] mul_idx;
        logic                 div_en;
        logic                 div_first;
        logic                 sqrt_en;
        logic                 sqrt_first;
        logic                 out_load;
    } cmd_t;

endpackage

// ===== src/cossim_ifs.sv =====
interface cossim_term_if;
    logic                                    valid;
    logic                                    ready;
    logic [cossim_pkg::ID_W-1:0]             page_id;
    logic signed [cossim_pkg::WEIGHT_W-1:0]  query_weight;
    logic signed [cossim_pkg::WEIGHT_W-1:0]  page_weight;
    logic                                    last_term;

    modport source (output valid, page_id, query_weight, page_weight, last_term,
                    input ready);
    modport sink (input valid, page_id, query_weight, page_weight, last_term,
                  output ready);
endinterface

interface cossim_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [cossim_pkg::ID_W-1:0]          result_page_id;
    logic signed [cossim_pkg::SIM_W-1:0]  similarity;
    logic                                 zero_norm;
    logic                                 too_many_terms;

    modport source (output valid, result_page_id, similarity, zero_norm, too_many_terms,
                    input ready);
    modport sink (input valid, result_page_id, similarity, zero_norm, too_many_terms,
                  output ready);
endinterface

// ===== src/cossim_ctrl.sv =====
module cossim_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cossim_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_ACCUM  = 5'b00001,
        ST_MULT   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_SQRT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    localparam logic [cossim_pkg::STEP_W-1:0] MULT_LAST =
        cossim_pkg::STEP_W'(cossim_pkg::MULT_STEPS - 1);
    localparam logic [cossim_pkg::STEP_W-1:0] DIV_LAST =
        cossim_pkg::STEP_W'(cossim_pkg::DIV_STEPS - 1);
    localparam logic [cossim_pkg::STEP_W-1:0] SQRT_LAST =
        cossim_pkg::STEP_W'(cossim_pkg::SQRT_STEPS - 1);

    state_t                          state_reg, state_next;
    logic [cossim_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_ACCUM);
    assign out_valid = out_valid_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                cmd.acc_en = in_valid;
                step_next  = '0;
                if (in_valid && in_last)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = step_reg[cossim_pkg::MUL_IDX_W-1:0];
                if (step_reg == MULT_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_en    = 1'b1;
                cmd.div_first = (step_reg == '0);
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_en    = 1'b1;
                cmd.sqrt_first = (step_reg == '0);
                if (step_reg == SQRT_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
                step_next  = '0;
            end
        endcase
    end

    // Result beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/cossim_datapath.sv =====
module cossim_datapath #(
    parameter int MAX_TERMS = cossim_pkg::DEF_MAX_TERMS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cossim_pkg::cmd_t                       cmd,
    input  logic [cossim_pkg::ID_W-1:0]            page_id,
    input  logic signed [cossim_pkg::WEIGHT_W-1:0] query_weight,
    input  logic signed [cossim_pkg::WEIGHT_W-1:0] page_weight,
    output logic [cossim_pkg::ID_W-1:0]            result_page_id,
    output logic signed [cossim_pkg::SIM_W-1:0]    similarity,
    output logic                                   zero_norm,
    output logic                                   too_many_terms
);

    localparam int PROD_W = 2 * cossim_pkg::WEIGHT_W;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int SUM_W  = PROD_W - 1 + CNT_W;
    localparam int HALF_W = (SUM_W + 1) / 2;
    localparam int OPND_W = 2 * HALF_W;
    localparam int ACC_W  = 4 * HALF_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

    localparam int QUOT_W = cossim_pkg::QUOT_W;
    localparam int RAD_W  = cossim_pkg::RAD_W;
    localparam int ROOT_W = cossim_pkg::ROOT_W;
    localparam int REM_W  = cossim_pkg::REM_W;
    localparam int SIM_W  = cossim_pkg::SIM_W;

    // Running sums
    logic signed [SUM_W-1:0] dot_reg, dot_next;
    logic [SUM_W-1:0]        qnorm_reg, qnorm_next;
    logic [SUM_W-1:0]        pnorm_reg, pnorm_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [cossim_pkg::ID_W-1:0] id_reg;

    logic signed [PROD_W-1:0] prod_qp, prod_qq, prod_pp;

    // Score calculation
    logic [ACC_W-1:0]  m_acc_reg, y_acc_reg;
    logic [ACC_W-1:0]  div_rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;

    // Term products
    assign prod_qp = query_weight * page_weight;
    assign prod_qq = query_weight * query_weight;
    assign prod_pp = page_weight * page_weight;

    // Accumulate a term, drop it past the limit, clear on result load
    always_comb
    begin
        dot_next   = dot_reg;
        qnorm_next = qnorm_reg;
        pnorm_next = pnorm_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.out_load)
        begin
            dot_next   = '0;
            qnorm_next = '0;
            pnorm_next = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (count_reg < MAX_CNT)
            begin
                dot_next   = dot_reg + SUM_W'(prod_qp);
                qnorm_next = qnorm_reg + SUM_W'(unsigned'(prod_qq));
                pnorm_next = pnorm_reg + SUM_W'(unsigned'(prod_pp));
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            qnorm_reg <= '0;
            pnorm_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            dot_reg   <= dot_next;
            qnorm_reg <= qnorm_next;
            pnorm_reg <= pnorm_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            id_reg <= page_id;
        end
    end

    // Shared half-width multiplier: dot^2 then qnorm*pnorm
    logic [SUM_W-1:0]    dot_mag;
    logic [OPND_W-1:0]   opnd_a, opnd_b;
    logic [HALF_W-1:0]   half_a, half_b;
    logic [OPND_W-1:0]   part_prod;
    logic [ACC_W-1:0]    part_shift;
    logic [ACC_W-1:0]    acc_base;
    logic [ACC_W-1:0]    acc_sum;

    assign dot_mag = dot_reg[SUM_W-1] ? SUM_W'(-dot_reg) : SUM_W'(dot_reg);

    always_comb
    begin
        opnd_a    = cmd.mul_idx[2] ? OPND_W'(qnorm_reg) : OPND_W'(dot_mag);
        opnd_b    = cmd.mul_idx[2] ? OPND_W'(pnorm_reg) : OPND_W'(dot_mag);
        half_a    = cmd.mul_idx[1] ? opnd_a[OPND_W-1:HALF_W] : opnd_a[HALF_W-1:0];
        half_b    = cmd.mul_idx[0] ? opnd_b[OPND_W-1:HALF_W] : opnd_b[HALF_W-1:0];
        part_prod = half_a * half_b;
        case (cmd.mul_idx[1:0])
            2'b00:   part_shift = ACC_W'(part_prod);
            2'b01:   part_shift = ACC_W'(part_prod) << HALF_W;
            2'b10:   part_shift = ACC_W'(part_prod) << HALF_W;
            2'b11:   part_shift = ACC_W'(part_prod) << (2 * HALF_W);
            default: part_shift = ACC_W'(part_prod);
        endcase
        // first partial product starts the accumulation
        if (cmd.mul_idx[1:0] == 2'b00)
        begin
            acc_base = '0;
        end
        else
        begin
            acc_base = cmd.mul_idx[2] ? y_acc_reg : m_acc_reg;
        end
        acc_sum = acc_base + part_shift;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            if (cmd.mul_idx[2])
            begin
                y_acc_reg <= acc_sum;
            end
            else
            begin
                m_acc_reg <= acc_sum;
            end
        end
    end

    // Restoring divider: quotient = floor(dot^2 * 2^30 / (qnorm*pnorm))
    logic [ACC_W:0]    div_cur;
    logic [ACC_W:0]    div_diff;
    logic              div_ge;

    assign div_cur  = cmd.div_first ? {1'b0, m_acc_reg} : {div_rem_reg, 1'b0};
    assign div_diff = div_cur - {1'b0, y_acc_reg};
    assign div_ge   = (div_cur >= {1'b0, y_acc_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_en)
        begin
            div_rem_reg <= div_ge ? div_diff[ACC_W-1:0] : div_cur[ACC_W-1:0];
            quot_reg    <= {quot_reg[QUOT_W-2:0], div_ge};
        end
    end

    // Digit-by-digit square root of the quotient, one root bit per step
    logic [RAD_W-1:0]  rad_cur;
    logic [REM_W-1:0]  sq_rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [REM_W-1:0]  sq_rem_shift;
    logic [REM_W-1:0]  sq_trial;
    logic              sq_ge;

    always_comb
    begin
        rad_cur      = cmd.sqrt_first ? {1'b0, quot_reg} : rad_reg;
        sq_rem_cur   = cmd.sqrt_first ? '0 : sq_rem_reg;
        root_cur     = cmd.sqrt_first ? '0 : root_reg;
        sq_rem_shift = {sq_rem_cur[REM_W-3:0], rad_cur[RAD_W-1:RAD_W-2]};
        sq_trial     = {1'b0, root_cur, 2'b01};
        sq_ge        = (sq_rem_shift >= sq_trial);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_en)
        begin
            rad_reg    <= {rad_cur[RAD_W-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? (sq_rem_shift - sq_trial) : sq_rem_shift;
            root_reg   <= {root_cur[ROOT_W-2:0], sq_ge};
        end
    end

    // Sign, saturation and zero-norm override
    logic             norm_zero;
    logic [SIM_W-1:0] sim_val;

    always_comb
    begin
        norm_zero = (qnorm_reg == '0) || (pnorm_reg == '0);
        if (norm_zero)
        begin
            sim_val = '0;
        end
        else if (dot_reg[SUM_W-1])
        begin
            sim_val = SIM_W'(~root_reg + 1'b1);
        end
        else if (root_reg[ROOT_W-1])
        begin
            sim_val = cossim_pkg::SIM_POS_MAX;
        end
        else
        begin
            sim_val = SIM_W'(root_reg);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_page_id <= id_reg;
            similarity     <= signed'(sim_val);
            zero_norm      <= norm_zero;
            too_many_terms <= ovf_reg;
        end
    end

endmodule

// ===== src/cosine_similarity_scorer_top.sv =====
// Cosine similarity scorer. Each term beat carries a query weight and a page
// weight (signed Q1.15); the block sums the dot product and both squared norms
// exactly and, on the beat marked last, returns the page id with
// dot / sqrt(qnorm * pnorm) in signed Q1.15, truncated toward zero and held to
// 32767 at the top. A zero norm gives 0 with zero_norm set; terms past
// MAX_TERMS are dropped and flagged. Term beats that are not last are taken one
// per cycle. A last beat starts the score calculation: dot^2 and qnorm*pnorm on
// a shared half-width multiplier (four partial products each), then restoring
// division and square root, then the load of the result register; term input
// reopens once that load is done, and the load waits while a previous result
// waits to be taken. Terms of the next vector stream in while a finished
// result sits in the output register.
module cosine_similarity_scorer_top #(
    parameter int MAX_TERMS = cossim_pkg::DEF_MAX_TERMS
) (
    input  logic             clk,
    input  logic             rst_n,
    cossim_term_if.sink      term,
    cossim_result_if.source  result
);

    cossim_pkg::cmd_t cmd;

    cossim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term.valid),
        .in_last   (term.last_term),
        .in_ready  (term.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    cossim_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .page_id        (term.page_id),
        .query_weight   (term.query_weight),
        .page_weight    (term.page_weight),
        .result_page_id (result.result_page_id),
        .similarity     (result.similarity),
        .zero_norm      (result.zero_norm),
        .too_many_terms (result.too_many_terms)
    );

endmodule

// ===== src/cossim_checker.sv =====
module cossim_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [cossim_pkg::ID_W-1:0]   out_page_id,
    input logic [cossim_pkg::SIM_W-1:0]  similarity,
    input logic                          zero_norm
);

    // A waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_page_id) && $stable(similarity))
        else $error("result beat changed while stalled");

    // Term input closes right after a last beat
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("term input still open after last beat");

    // Input closes only because of a last beat
    a_close_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_last))
        else $error("term input closed without a last beat");

    // Zero norm forces a zero score
    a_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> similarity == '0)
        else $error("zero norm with nonzero similarity");

    // A new result appears only after the calculation held the input closed
    a_result_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready) == 1'b0)
        else $error("result appeared while term input was open");

endmodule

bind cosine_similarity_scorer_top cossim_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (term.valid),
    .in_ready    (term.ready),
    .in_last     (term.last_term),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_page_id (result.result_page_id),
    .similarity  (result.similarity),
    .zero_norm   (result.zero_norm)
);
